@@ src/palette_patch_blit_assert.svh @@
// Assertion macros used by the palette patch blitter checker.
`ifndef PALETTE_PATCH_BLIT_ASSERT_SVH
`define PALETTE_PATCH_BLIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define PPB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define PPB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define PPB_ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/ppb_pkg.sv @@
// Package with the types, codes and constants of the palette patch blitter.
package ppb_pkg;

   localparam int DEF_PALETTE_DEPTH = 256;
   localparam int DEF_MAX_TEX_DIM   = 1024;

   localparam int COORD_W  = 10;
   localparam int INDEX_W  = 8;
   localparam int CHAN_W   = 8;
   localparam int COLOR_W  = 3 * CHAN_W;
   localparam int DEST_W   = 20;
   localparam int DIMREG_W = 11;
   localparam int ORIGIN_W = 16;
   localparam int COUNT_W  = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   localparam logic CMD_BLIT = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam logic [DIMREG_W-1:0] RST_TEX_WIDTH     = 11'd64;
   localparam logic [DIMREG_W-1:0] RST_TEX_HEIGHT    = 11'd128;
   localparam logic [ORIGIN_W-1:0] RST_ORIGIN        = 16'd0;
   localparam logic [COUNT_W-1:0]  RST_PALETTE_COUNT = 9'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TEX_WIDTH     = 3'd0,
      REG_TEX_HEIGHT    = 3'd1,
      REG_PLACE_X       = 3'd2,
      REG_PLACE_Y       = 3'd3,
      REG_PALETTE_COUNT = 3'd4
   } ppb_reg_type;

   typedef struct packed {
      logic [DIMREG_W-1:0] tex_width;
      logic [DIMREG_W-1:0] tex_height;
      logic [ORIGIN_W-1:0] place_x;
      logic [ORIGIN_W-1:0] place_y;
      logic [COUNT_W-1:0]  palette_count;
   } ppb_cfg_type;

endpackage

@@ src/ppb_if.sv @@
// Channel interfaces of the palette patch blitter: requests, results and register writes.
interface ppb_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [9:0] pixel_x;
   logic [9:0] pixel_y;
   logic [7:0] color_index;
   logic [7:0] load_red;
   logic [7:0] load_green;
   logic [7:0] load_blue;

   modport source (output valid, cmd, pixel_x, pixel_y, color_index, load_red, load_green,
                   load_blue, input ready);
   modport sink (input valid, cmd, pixel_x, pixel_y, color_index, load_red, load_green,
                 load_blue, output ready);
endinterface

interface ppb_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] dest_pixel_index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;

   modport source (output valid, dest_pixel_index, red, green, blue, alpha, input ready);
   modport sink (input valid, dest_pixel_index, red, green, blue, alpha, output ready);
endinterface

interface ppb_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/ppb_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module ppb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ppb_csr.sv @@
// Configuration registers of the palette patch blitter.
module ppb_csr
   import ppb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ppb_csr_if.sink     csr_bus,
   output ppb_cfg_type cfg
);

   ppb_cfg_type cfg_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tex_width     <= RST_TEX_WIDTH;
         cfg_ff.tex_height    <= RST_TEX_HEIGHT;
         cfg_ff.place_x       <= RST_ORIGIN;
         cfg_ff.place_y       <= RST_ORIGIN;
         cfg_ff.palette_count <= RST_PALETTE_COUNT;
      end else if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            REG_TEX_WIDTH:     cfg_ff.tex_width     <= csr_bus.data[DIMREG_W-1:0];
            REG_TEX_HEIGHT:    cfg_ff.tex_height    <= csr_bus.data[DIMREG_W-1:0];
            REG_PLACE_X:       cfg_ff.place_x       <= csr_bus.data[ORIGIN_W-1:0];
            REG_PLACE_Y:       cfg_ff.place_y       <= csr_bus.data[ORIGIN_W-1:0];
            REG_PALETTE_COUNT: cfg_ff.palette_count <= csr_bus.data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/ppb_front.sv @@
// Input register, clipping and palette checks, and the palette memory access.
module ppb_front
   import ppb_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
   parameter int MAX_TEX_DIM   = DEF_MAX_TEX_DIM
) (
   input  logic                               clock,
   input  logic                               reset,
   ppb_req_if.sink                            req_bus,
   input  ppb_cfg_type                        cfg,
   input  logic                               down_ready,
   output logic                               s2_valid,
   output logic [$clog2(MAX_TEX_DIM)-1:0]     s2_dx,
   output logic [$clog2(MAX_TEX_DIM)-1:0]     s2_dy,
   output logic [$clog2(MAX_TEX_DIM+1)-1:0]   s2_width,
   output logic [COLOR_W-1:0]                 s2_color
);

   localparam int CW = $clog2(MAX_TEX_DIM);
   localparam int DW = $clog2(MAX_TEX_DIM + 1);
   localparam int AW = $clog2(PALETTE_DEPTH);

   logic                s1_valid_ff;
   logic                s1_cmd_ff;
   logic [COORD_W-1:0]  s1_x_ff;
   logic [COORD_W-1:0]  s1_y_ff;
   logic [INDEX_W-1:0]  s1_idx_ff;
   logic [COLOR_W-1:0]  s1_rgb_ff;
   logic                s2_valid_ff;
   logic [CW-1:0]       s2_dx_ff;
   logic [CW-1:0]       s2_dy_ff;
   logic [DW-1:0]       s2_width_ff;

   logic                s2_open;
   logic                s1_adv;
   logic [DW-1:0]       width_c;
   logic [DW-1:0]       height_c;
   logic signed [16:0]  dx;
   logic signed [16:0]  dy;
   logic                x_ok;
   logic                y_ok;
   logic                depth_ok;
   logic                index_ok;
   logic                keep;
   logic                wr_en;
   logic                rd_en;

   assign s2_open       = !s2_valid_ff || down_ready;
   assign s1_adv        = s1_valid_ff && s2_open;
   assign req_bus.ready = !s1_valid_ff || s2_open;

   always_comb begin
      if (32'(cfg.tex_width) > MAX_TEX_DIM) begin
         width_c = DW'(MAX_TEX_DIM);
      end else begin
         width_c = DW'(cfg.tex_width);
      end
      if (32'(cfg.tex_height) > MAX_TEX_DIM) begin
         height_c = DW'(MAX_TEX_DIM);
      end else begin
         height_c = DW'(cfg.tex_height);
      end
   end

   assign dx = $signed({cfg.place_x[ORIGIN_W-1], cfg.place_x}) + $signed({7'd0, s1_x_ff});
   assign dy = $signed({cfg.place_y[ORIGIN_W-1], cfg.place_y}) + $signed({7'd0, s1_y_ff});

   assign x_ok     = !dx[16] && (dx[15:0] < 16'(width_c));
   assign y_ok     = !dy[16] && (dy[15:0] < 16'(height_c));
   assign depth_ok = 32'(s1_idx_ff) < 32'(PALETTE_DEPTH);
   assign index_ok = depth_ok && ({1'b0, s1_idx_ff} < cfg.palette_count) && (s1_idx_ff != '0);
   assign keep     = (s1_cmd_ff == CMD_BLIT) && x_ok && y_ok && index_ok;
   assign wr_en    = s1_adv && (s1_cmd_ff == CMD_LOAD) && depth_ok;
   assign rd_en    = s1_adv && (s1_cmd_ff == CMD_BLIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_open) begin
            s2_valid_ff <= s1_valid_ff && keep;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s1_cmd_ff <= req_bus.cmd;
         s1_x_ff   <= req_bus.pixel_x;
         s1_y_ff   <= req_bus.pixel_y;
         s1_idx_ff <= req_bus.color_index;
         s1_rgb_ff <= {req_bus.load_red, req_bus.load_green, req_bus.load_blue};
      end
      if (s1_adv) begin
         s2_dx_ff    <= dx[CW-1:0];
         s2_dy_ff    <= dy[CW-1:0];
         s2_width_ff <= width_c;
      end
   end

   ppb_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_idx_ff[AW-1:0]),
      .wr_data (s1_rgb_ff),
      .rd_en   (rd_en),
      .rd_addr (s1_idx_ff[AW-1:0]),
      .rd_data (s2_color)
   );

   assign s2_valid = s2_valid_ff;
   assign s2_dx    = s2_dx_ff;
   assign s2_dy    = s2_dy_ff;
   assign s2_width = s2_width_ff;

endmodule

@@ src/ppb_back.sv @@
// Row multiply, address add and the result register of the palette patch blitter.
module ppb_back
   import ppb_pkg::*;
#(
   parameter int MAX_TEX_DIM = DEF_MAX_TEX_DIM
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               s2_valid,
   input  logic [$clog2(MAX_TEX_DIM)-1:0]     s2_dx,
   input  logic [$clog2(MAX_TEX_DIM)-1:0]     s2_dy,
   input  logic [$clog2(MAX_TEX_DIM+1)-1:0]   s2_width,
   input  logic [COLOR_W-1:0]                 s2_color,
   output logic                               down_ready,
   ppb_rsp_if.source                          rsp_bus
);

   localparam int CW = $clog2(MAX_TEX_DIM);
   localparam int DW = $clog2(MAX_TEX_DIM + 1);
   localparam int PW = CW + DW;
   localparam int SW = (PW + 1 > DEST_W) ? PW + 1 : DEST_W;

   logic               s3_valid_ff;
   logic [PW-1:0]      s3_prod_ff;
   logic [CW-1:0]      s3_dx_ff;
   logic [COLOR_W-1:0] s3_color_ff;
   logic               rsp_valid_ff;
   logic [DEST_W-1:0]  rsp_dest_ff;
   logic [COLOR_W-1:0] rsp_color_ff;

   logic               s3_open;
   logic               out_open;
   logic [SW-1:0]      dest_sum;

   assign out_open   = !rsp_valid_ff || rsp_bus.ready;
   assign s3_open    = !s3_valid_ff || out_open;
   assign down_ready = s3_open;
   assign dest_sum   = SW'(s3_prod_ff) + SW'(s3_dx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s3_open) begin
            s3_valid_ff <= s2_valid;
         end
         if (out_open) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid && s3_open) begin
         s3_prod_ff  <= PW'(s2_dy * s2_width);
         s3_dx_ff    <= s2_dx;
         s3_color_ff <= s2_color;
      end
      if (s3_valid_ff && out_open) begin
         rsp_dest_ff  <= dest_sum[DEST_W-1:0];
         rsp_color_ff <= s3_color_ff;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.dest_pixel_index = rsp_dest_ff;
   assign rsp_bus.red              = rsp_color_ff[3*CHAN_W-1:2*CHAN_W];
   assign rsp_bus.green            = rsp_color_ff[2*CHAN_W-1:CHAN_W];
   assign rsp_bus.blue             = rsp_color_ff[CHAN_W-1:0];
   assign rsp_bus.alpha            = ALPHA_OPAQUE;

endmodule

@@ src/palette_patch_blit.sv @@
// Top level of the palette-indexed patch blitter with colour key and clipping.
//
//   Channel   Direction   Carries
//   req_bus   in          blit pixel (x, y, index) or palette load (address, RGB)
//   rsp_bus   out         destination pixel index and RGBA bytes
//   csr_bus   in          register writes: width, height, origin x/y, palette count
//
// A request is taken every cycle unless a stall at the result has backed up to the input.
// A surviving pixel passes four register stages in order: input, clip and palette
// read, row multiply, result register; the first loads at the edge that accepts it.
// Loads, clipped, transparent and out-of-palette pixels give no result and leave the pipe.
// Reset clears valid bits and loads CSR defaults; the palette is undefined until loaded.
// A stall at the result holds each stage in place and frees empty stages for new requests.
module palette_patch_blit
   import ppb_pkg::*;
#(
   parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
   parameter int MAX_TEX_DIM   = DEF_MAX_TEX_DIM
) (
   input  logic      clock,
   input  logic      reset,
   ppb_req_if.sink   req_bus,
   ppb_rsp_if.source rsp_bus,
   ppb_csr_if.sink   csr_bus
);

   localparam int CW = $clog2(MAX_TEX_DIM);
   localparam int DW = $clog2(MAX_TEX_DIM + 1);

   ppb_cfg_type        cfg;
   logic               down_ready;
   logic               s2_valid;
   logic [CW-1:0]      s2_dx;
   logic [CW-1:0]      s2_dy;
   logic [DW-1:0]      s2_width;
   logic [COLOR_W-1:0] s2_color;

   ppb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   ppb_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .MAX_TEX_DIM   (MAX_TEX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg),
      .down_ready (down_ready),
      .s2_valid   (s2_valid),
      .s2_dx      (s2_dx),
      .s2_dy      (s2_dy),
      .s2_width   (s2_width),
      .s2_color   (s2_color)
   );

   ppb_back #(
      .MAX_TEX_DIM (MAX_TEX_DIM)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .s2_valid   (s2_valid),
      .s2_dx      (s2_dx),
      .s2_dy      (s2_dy),
      .s2_width   (s2_width),
      .s2_color   (s2_color),
      .down_ready (down_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

@@ src/ppb_checker.sv @@
// Port-level assertions for the palette patch blitter and their bind to the top level.
`include "palette_patch_blit_assert.svh"

module ppb_checker
   import ppb_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DEST_W-1:0] rsp_dest,
   input logic [CHAN_W-1:0] rsp_red,
   input logic [CHAN_W-1:0] rsp_green,
   input logic [CHAN_W-1:0] rsp_blue,
   input logic [CHAN_W-1:0] rsp_alpha,
   input logic              csr_valid,
   input logic              csr_ready
);

   `PPB_ASSERT_NXT_ALL(a_reset_empty, clock, reset, !rsp_valid, "result valid after reset")

   `PPB_ASSERT_IMP(a_alpha_opaque, clock, reset, rsp_valid, rsp_alpha == ALPHA_OPAQUE,
                   "alpha not opaque")

   `PPB_ASSERT_IMP(a_flow_through, clock, reset, rsp_ready, req_ready,
                   "request blocked while results drain")

   `PPB_ASSERT_IMP(a_csr_ready, clock, reset, csr_valid, csr_ready, "register write refused")

   `PPB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_dest) && $stable(rsp_red) &&
                   $stable(rsp_green) && $stable(rsp_blue),
                   "stalled result changed")

endmodule

bind palette_patch_blit ppb_checker u_ppb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_dest  (rsp_bus.dest_pixel_index),
   .rsp_red   (rsp_bus.red),
   .rsp_green (rsp_bus.green),
   .rsp_blue  (rsp_bus.blue),
   .rsp_alpha (rsp_bus.alpha),
   .csr_valid (csr_bus.valid),
   .csr_ready (csr_bus.ready)
);
